// File: rtl/core/rac_pkg.sv
// ----------------------------------------------------------------------------
// rac_pkg
// Shared types, constants and helpers for the register allocator with spill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rac_pkg;

    localparam int NUM_REGS   = 16;
    localparam int REG_W      = $clog2(NUM_REGS);
    localparam int CMD_W      = 4;
    localparam int IDX_W      = 4;
    localparam int DIST_W     = 14;
    localparam int BASE_W     = 15;
    localparam int SLOT_W     = 16;
    localparam int MEMOP_W    = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [DIST_W-1:0] LONG_LIFE  = DIST_W'(10000);
    localparam logic [BASE_W-1:0] BASE_RESET = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC       = 4'd0,
        CMD_ALLOC_PIN   = 4'd1,
        CMD_LOCK        = 4'd2,
        CMD_UNLOCK      = 4'd3,
        CMD_UNLOCK_PIN  = 4'd4,
        CMD_MARK_LIVE   = 4'd5,
        CMD_TICK_ONE    = 4'd6,
        CMD_TICK_ALL    = 4'd7,
        CMD_SPILL       = 4'd8,
        CMD_FORCE_SPILL = 4'd9,
        CMD_ENSURE      = 4'd10,
        CMD_QUERY       = 4'd11,
        CMD_NEW_FUNC    = 4'd12
    } rac_cmd_t;

    typedef enum logic [MEMOP_W-1:0] {
        MEM_NONE  = 2'd0,
        MEM_STORE = 2'd1,
        MEM_LOAD  = 2'd2
    } rac_memop_t;

    localparam logic CFG_IDX_BASE = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_FINISH
    } rac_state_t;

    typedef struct packed {
        logic capture;
        logic start_scan;
        logic scan_step;
        logic commit;
    } rac_ctl_t;

    typedef struct packed {
        logic need_scan;
        logic scan_last;
        logic out_free;
    } rac_sts_t;

    function automatic logic [REG_W-1:0] first_set(input logic [NUM_REGS-1:0] vec);
        logic [REG_W-1:0] pick;
        pick = '0;
        for (int i = NUM_REGS - 1; i >= 0; i--) begin
            if (vec[i])
            begin
                pick = REG_W'(i);
            end
        end
        return pick;
    endfunction

    function automatic logic signed [SLOT_W-1:0] slot_of(
        input logic signed [BASE_W-1:0] base,
        input logic [REG_W-1:0]         idx
    );
        logic signed [SLOT_W-1:0] base_ext;
        logic [SLOT_W-1:0]        idx_ext;
        base_ext = SLOT_W'(base);
        idx_ext  = SLOT_W'(idx);
        return base_ext - idx_ext - SLOT_W'(1);
    endfunction

endpackage

// File: rtl/core/rac_ifs.sv
// ----------------------------------------------------------------------------
// rac_ifs
// Valid/ready channel interfaces for command and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rac_cmd_if;
    import rac_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  reg_index;
    logic [DIST_W-1:0] live_distance;

    modport source (output valid, output command, output reg_index,
                    output live_distance, input ready);
    modport sink   (input valid, input command, input reg_index,
                    input live_distance, output ready);
endinterface

interface rac_res_if;
    import rac_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     status;
    logic [IDX_W-1:0]         result_reg;
    logic                     is_locked;
    logic [MEMOP_W-1:0]       mem_op;
    logic [IDX_W-1:0]         mem_reg;
    logic signed [SLOT_W-1:0] mem_slot;

    modport source (output valid, output status, output result_reg, output is_locked,
                    output mem_op, output mem_reg, output mem_slot, input ready);
    modport sink   (input valid, input status, input result_reg, input is_locked,
                    input mem_op, input mem_reg, input mem_slot, output ready);
endinterface

// File: rtl/core/rac_ctrl.sv
// ----------------------------------------------------------------------------
// rac_ctrl
// Sequencer: capture, decode, optional farthest-use scan, commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rac_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rac_pkg::rac_sts_t sts,
    output rac_pkg::rac_ctl_t ctl
);
    import rac_pkg::*;

    rac_state_t state_reg;
    rac_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = sts.need_scan ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        ctl.capture    = 1'b0;
        ctl.start_scan = 1'b0;
        ctl.scan_step  = 1'b0;
        ctl.commit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctl.capture = in_valid;
            end
            ST_DECODE:
            begin
                ctl.start_scan = sts.need_scan;
            end
            ST_SCAN:
            begin
                ctl.scan_step = 1'b1;
            end
            ST_FINISH:
            begin
                ctl.commit = sts.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: rtl/core/rac_datapath.sv
// ----------------------------------------------------------------------------
// rac_datapath
// Register file state, candidate selection, farthest-use scan, result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rac_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rac_pkg::rac_ctl_t                 ctl,
    output rac_pkg::rac_sts_t                 sts,
    input  logic [rac_pkg::CMD_W-1:0]         command,
    input  logic [rac_pkg::IDX_W-1:0]         reg_index,
    input  logic [rac_pkg::DIST_W-1:0]        live_distance,
    input  logic signed [rac_pkg::BASE_W-1:0] base,
    input  logic                              res_ready,
    output logic                              res_valid,
    output logic                              status,
    output logic [rac_pkg::IDX_W-1:0]         result_reg,
    output logic                              is_locked,
    output logic [rac_pkg::MEMOP_W-1:0]       mem_op,
    output logic [rac_pkg::IDX_W-1:0]         mem_reg,
    output logic signed [rac_pkg::SLOT_W-1:0] mem_slot
);
    import rac_pkg::*;

    logic [NUM_REGS-1:0]      alloc_bits_reg;
    logic [NUM_REGS-1:0]      alloc_bits_next;
    logic [NUM_REGS-1:0]      pin_bits_reg;
    logic [NUM_REGS-1:0]      pin_bits_next;
    logic signed [SLOT_W-1:0] pend_slot_reg [NUM_REGS];
    logic signed [SLOT_W-1:0] pend_slot_next [NUM_REGS];
    logic [DIST_W-1:0]        use_dist_reg [NUM_REGS];
    logic [DIST_W-1:0]        use_dist_next [NUM_REGS];

    logic [CMD_W-1:0]         cmd_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [DIST_W-1:0]        dist_reg;

    logic [REG_W-1:0]         scan_idx_reg;
    logic                     best_found_reg;
    logic [REG_W-1:0]         best_idx_reg;
    logic [DIST_W-1:0]        best_dist_reg;

    logic                     out_valid_reg;
    logic                     status_reg;
    logic [IDX_W-1:0]         result_reg_reg;
    logic                     locked_reg;
    logic [MEMOP_W-1:0]       mem_op_reg;
    logic [IDX_W-1:0]         mem_reg_reg;
    logic signed [SLOT_W-1:0] mem_slot_reg;

    logic                     status_next;
    logic [IDX_W-1:0]         result_next;
    logic                     locked_next;
    logic [MEMOP_W-1:0]       mem_op_next;
    logic [IDX_W-1:0]         mem_reg_next;
    logic signed [SLOT_W-1:0] mem_slot_next;

    logic [NUM_REGS-1:0]      zero_vec;
    logic [NUM_REGS-1:0]      free_vec;
    logic [NUM_REGS-1:0]      dead_vec;
    logic [REG_W-1:0]         free_pick;
    logic [REG_W-1:0]         dead_pick;
    logic [REG_W-1:0]         rd_addr;
    logic [DIST_W-1:0]        rd_dist;
    logic [REG_W-1:0]         r_sel;
    logic                     reg_ok;
    logic                     is_alloc;
    logic                     scan_hit;

    // Candidate vectors; register 0 is never handed out
    always_comb
    begin
        for (int i = 0; i < NUM_REGS; i++) begin
            zero_vec[i] = (use_dist_reg[i] == '0);
        end
        free_vec    = ~alloc_bits_reg & ~pin_bits_reg;
        dead_vec    = alloc_bits_reg & ~pin_bits_reg & zero_vec;
        free_vec[0] = 1'b0;
        dead_vec[0] = 1'b0;
    end

    assign free_pick = first_set(free_vec);
    assign dead_pick = first_set(dead_vec);
    assign r_sel     = REG_W'(idx_reg);
    assign reg_ok    = (int'(idx_reg) < NUM_REGS);
    assign is_alloc  = (cmd_reg == CMD_ALLOC) || (cmd_reg == CMD_ALLOC_PIN);

    assign rd_addr  = ctl.scan_step ? scan_idx_reg : r_sel;
    assign rd_dist  = use_dist_reg[rd_addr];
    assign scan_hit = alloc_bits_reg[scan_idx_reg] && !pin_bits_reg[scan_idx_reg]
                      && (!best_found_reg || rd_dist > best_dist_reg);

    assign sts.need_scan = is_alloc && !(|free_vec) && !(|dead_vec);
    assign sts.scan_last = (scan_idx_reg == REG_W'(NUM_REGS - 1));
    assign sts.out_free  = !out_valid_reg || res_ready;

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg  <= command;
            idx_reg  <= reg_index;
            dist_reg <= live_distance;
        end
    end

    // Farthest-next-use scan, first wins on ties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_found_reg <= 1'b0;
        end
        else if (ctl.start_scan)
        begin
            best_found_reg <= 1'b0;
        end
        else if (ctl.scan_step && scan_hit)
        begin
            best_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start_scan)
        begin
            scan_idx_reg <= REG_W'(1);
        end
        else if (ctl.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + REG_W'(1);
            if (scan_hit)
            begin
                best_idx_reg  <= scan_idx_reg;
                best_dist_reg <= rd_dist;
            end
        end
    end

    always_comb
    begin
        logic uses_reg;
        uses_reg        = 1'b0;
        alloc_bits_next = alloc_bits_reg;
        pin_bits_next   = pin_bits_reg;
        for (int i = 0; i < NUM_REGS; i++) begin
            pend_slot_next[i] = pend_slot_reg[i];
            use_dist_next[i]  = use_dist_reg[i];
        end
        status_next   = 1'b0;
        result_next   = idx_reg;
        locked_next   = 1'b0;
        mem_op_next   = MEM_NONE;
        mem_reg_next  = '0;
        mem_slot_next = '0;

        case (cmd_reg)
            CMD_ALLOC, CMD_ALLOC_PIN:
            begin
                locked_next = 1'b1;
                if (|free_vec)
                begin
                    alloc_bits_next[free_pick] = 1'b1;
                    use_dist_next[free_pick]   = '0;
                    result_next                = IDX_W'(free_pick);
                    if (cmd_reg == CMD_ALLOC_PIN)
                    begin
                        pin_bits_next[free_pick] = 1'b1;
                    end
                end
                else if (|dead_vec)
                begin
                    result_next = IDX_W'(dead_pick);
                    if (cmd_reg == CMD_ALLOC_PIN)
                    begin
                        pin_bits_next[dead_pick] = 1'b1;
                    end
                end
                else if (best_found_reg)
                begin
                    pend_slot_next[best_idx_reg] = '0;
                    use_dist_next[best_idx_reg]  = LONG_LIFE;
                    result_next                  = IDX_W'(best_idx_reg);
                    mem_op_next                  = MEM_STORE;
                    mem_reg_next                 = IDX_W'(best_idx_reg);
                    mem_slot_next                = slot_of(base, best_idx_reg);
                    if (cmd_reg == CMD_ALLOC_PIN)
                    begin
                        pin_bits_next[best_idx_reg] = 1'b1;
                    end
                end
                else
                begin
                    status_next = 1'b1;
                    result_next = '0;
                    locked_next = 1'b0;
                end
            end
            CMD_TICK_ALL:
            begin
                result_next = '0;
                for (int i = 0; i < NUM_REGS; i++) begin
                    if (use_dist_reg[i] != '0)
                    begin
                        use_dist_next[i] = use_dist_reg[i] - DIST_W'(1);
                    end
                end
            end
            CMD_NEW_FUNC:
            begin
                result_next = '0;
                for (int i = 0; i < NUM_REGS; i++) begin
                    pend_slot_next[i] = '0;
                    use_dist_next[i]  = '0;
                end
            end
            CMD_LOCK:
            begin
                uses_reg = reg_ok;
                if (reg_ok)
                begin
                    alloc_bits_next[r_sel] = 1'b1;
                    use_dist_next[r_sel]   = LONG_LIFE;
                end
            end
            CMD_UNLOCK, CMD_UNLOCK_PIN:
            begin
                uses_reg = reg_ok;
                if (reg_ok)
                begin
                    alloc_bits_next[r_sel] = 1'b0;
                    use_dist_next[r_sel]   = '0;
                    if (cmd_reg == CMD_UNLOCK_PIN)
                    begin
                        pin_bits_next[r_sel] = 1'b0;
                    end
                end
            end
            CMD_MARK_LIVE:
            begin
                uses_reg = reg_ok;
                if (reg_ok)
                begin
                    use_dist_next[r_sel] = dist_reg;
                end
            end
            CMD_TICK_ONE:
            begin
                uses_reg = reg_ok;
                if (reg_ok && rd_dist != '0)
                begin
                    use_dist_next[r_sel] = rd_dist - DIST_W'(1);
                end
            end
            CMD_SPILL, CMD_FORCE_SPILL:
            begin
                uses_reg = reg_ok;
                if (reg_ok && !(cmd_reg == CMD_SPILL && pin_bits_reg[r_sel]))
                begin
                    pend_slot_next[r_sel]  = slot_of(base, r_sel);
                    alloc_bits_next[r_sel] = 1'b0;
                    mem_op_next            = MEM_STORE;
                    mem_reg_next           = idx_reg;
                    mem_slot_next          = slot_of(base, r_sel);
                end
            end
            CMD_ENSURE:
            begin
                uses_reg = reg_ok;
                if (reg_ok && pend_slot_reg[r_sel] != '0)
                begin
                    pend_slot_next[r_sel]  = '0;
                    alloc_bits_next[r_sel] = 1'b1;
                    mem_op_next            = MEM_LOAD;
                    mem_reg_next           = idx_reg;
                    mem_slot_next          = pend_slot_reg[r_sel];
                end
            end
            CMD_QUERY:
            begin
                uses_reg = reg_ok;
            end
            default:
            begin
                result_next = '0;
            end
        endcase

        if (uses_reg)
        begin
            locked_next = alloc_bits_next[r_sel];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_bits_reg <= NUM_REGS'(1);
            pin_bits_reg   <= '0;
            for (int i = 0; i < NUM_REGS; i++) begin
                pend_slot_reg[i] <= '0;
                use_dist_reg[i]  <= '0;
            end
        end
        else if (ctl.commit)
        begin
            alloc_bits_reg <= alloc_bits_next;
            pin_bits_reg   <= pin_bits_next;
            for (int i = 0; i < NUM_REGS; i++) begin
                pend_slot_reg[i] <= pend_slot_next[i];
                use_dist_reg[i]  <= use_dist_next[i];
            end
        end
    end

    // Result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            status_reg     <= status_next;
            result_reg_reg <= result_next;
            locked_reg     <= locked_next;
            mem_op_reg     <= mem_op_next;
            mem_reg_reg    <= mem_reg_next;
            mem_slot_reg   <= mem_slot_next;
        end
    end

    assign res_valid  = out_valid_reg;
    assign status     = status_reg;
    assign result_reg = result_reg_reg;
    assign is_locked  = locked_reg;
    assign mem_op     = mem_op_reg;
    assign mem_reg    = mem_reg_reg;
    assign mem_slot   = mem_slot_reg;

endmodule

// File: rtl/core/register_allocator_with_spill_core.sv
// ----------------------------------------------------------------------------
// register_allocator_with_spill_core
// Register allocator with farthest-next-use spill, APB offset register.
// Flow: capture, decode, then commit to the registered result word; a
//   spilling allocation first runs the one-entry-a-cycle scan.
// One command at a time: a new one is accepted only after the last commits.
// Reset: register 0 allocated, all else cleared, spill base offset -1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module register_allocator_with_spill_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rac_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [rac_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [rac_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    rac_cmd_if.sink                           cmd,
    rac_res_if.source                         res
);
    import rac_pkg::*;

    logic signed [BASE_W-1:0] base_reg;
    logic                     cfg_hit;
    rac_ctl_t                 ctl;
    rac_sts_t                 sts;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[CFG_ADDR_W-1] == CFG_IDX_BASE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
        end
        else if (psel && penable && pwrite && cfg_hit)
        begin
            base_reg <= pwdata[BASE_W-1:0];
        end
    end

    assign prdata = cfg_hit ? CFG_DATA_W'(base_reg) : '0;

    rac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    rac_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .command       (cmd.command),
        .reg_index     (cmd.reg_index),
        .live_distance (cmd.live_distance),
        .base          (base_reg),
        .res_ready     (res.ready),
        .res_valid     (res.valid),
        .status        (res.status),
        .result_reg    (res.result_reg),
        .is_locked     (res.is_locked),
        .mem_op        (res.mem_op),
        .mem_reg       (res.mem_reg),
        .mem_slot      (res.mem_slot)
    );

`ifndef SYNTH
    a_one_word_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("command accepted while previous word still in progress");

    a_fail_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status |-> res.result_reg == '0 && !res.is_locked
                                    && res.mem_op == MEM_NONE)
        else $error("failed allocation carries a register or memory operation");

    a_no_memop_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.mem_op == MEM_NONE |-> res.mem_reg == '0 && res.mem_slot == '0)
        else $error("memory fields set without a memory operation");

    a_memop_locked: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.mem_op == MEM_LOAD |-> res.is_locked && res.mem_reg == res.result_reg)
        else $error("restored register not reported as allocated");
`endif

endmodule
